@@ hw/rtl/btpc_pkg.sv @@
package btpc_pkg;

	// sizes of the data path
	localparam int LEVEL_BITS    = 16;
	localparam int POSITION_BITS = 16;
	localparam int FRAC_BITS     = 16;

	localparam int GAIN_W   = 32;
	localparam int RESP_W   = 32;
	localparam int MANUAL_W = 17;
	localparam int CMD_W    = 2;
	localparam int USER_W   = CMD_W + 1;

	// divider / serial multiplier sizes
	localparam int SUM_W  = LEVEL_BITS + 1;
	localparam int REM_W  = SUM_W + 1;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(Q_W);
	localparam int PROD_W = GAIN_W + Q_W;
	localparam int MAG_W  = PROD_W - FRAC_BITS;

	// gain after reset is 1.0
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;

	// stream packing
	localparam int IN_W      = MANUAL_W + 4 * LEVEL_BITS;
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OFS_MAN   = 0;
	localparam int OFS_HP    = OFS_MAN + MANUAL_W;
	localparam int OFS_HM    = OFS_HP + LEVEL_BITS;
	localparam int OFS_VP    = OFS_HM + LEVEL_BITS;
	localparam int OFS_VM    = OFS_VP + LEVEL_BITS;
	localparam int OUT_W     = 2 * RESP_W + 2 * POSITION_BITS;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TRACK = 2'd0,
		CMD_CHECK = 2'd1,
		CMD_SET   = 2'd2,
		CMD_ADD   = 2'd3
	} cmd_t;

	// request into the shared axis unit
	typedef struct packed {
		logic                  start;
		logic [LEVEL_BITS-1:0] plus;
		logic [LEVEL_BITS-1:0] minus;
	} div_req_t;

	// result out of the shared axis unit
	typedef struct packed {
		logic                     done;
		logic signed [RESP_W-1:0] resp;
	} div_res_t;

endpackage

@@ hw/rtl/btpc_axis_unit.sv @@
// One axis response: restoring divide (n-p)/(p+n), one quotient bit per cycle,
// MSB first, folded straight into a shift-add multiply by |gain|.
module btpc_axis_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  btpc_pkg::div_req_t                   req,
	input  logic signed [btpc_pkg::GAIN_W-1:0]   gain,
	output btpc_pkg::div_res_t                   res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t                            state_q;
	logic [btpc_pkg::CNT_W-1:0]        cnt_q;
	logic                              done_q;
	logic [btpc_pkg::REM_W-1:0]        rem_q;
	logic [btpc_pkg::SUM_W-1:0]        sum_q;
	logic [btpc_pkg::GAIN_W-1:0]       gmag_q;
	logic [btpc_pkg::PROD_W-1:0]       acc_q;
	logic                              neg_q;
	logic signed [btpc_pkg::RESP_W-1:0] resp_q;

	logic                              qbit;
	logic [btpc_pkg::REM_W-1:0]        rem_sub;
	logic [btpc_pkg::REM_W-1:0]        rem_next;
	logic [btpc_pkg::PROD_W-1:0]       acc_next;
	logic [btpc_pkg::SUM_W-1:0]        ld_sum;
	logic [btpc_pkg::LEVEL_BITS-1:0]   ld_diff;
	logic [btpc_pkg::MAG_W-1:0]        mag;
	logic [btpc_pkg::MAG_W-1:0]        mag_neg;
	logic signed [btpc_pkg::RESP_W-1:0] resp_fin;

	// operand load
	assign ld_sum  = btpc_pkg::SUM_W'(req.plus) + btpc_pkg::SUM_W'(req.minus);
	assign ld_diff = (req.plus >= req.minus) ? req.plus - req.minus : req.minus - req.plus;

	// one divide step; a zero sum yields a zero quotient
	assign qbit     = (sum_q != '0) && (rem_q >= btpc_pkg::REM_W'(sum_q));
	assign rem_sub  = qbit ? rem_q - btpc_pkg::REM_W'(sum_q) : rem_q;
	assign rem_next = {rem_sub[btpc_pkg::REM_W-2:0], 1'b0};

	// Horner multiply by |gain| on the quotient bits
	assign acc_next = {acc_q[btpc_pkg::PROD_W-2:0], 1'b0}
		+ (qbit ? btpc_pkg::PROD_W'(gmag_q) : '0);

	// drop fraction, restore sign, saturate a positive result
	assign mag     = acc_q[btpc_pkg::FRAC_BITS +: btpc_pkg::MAG_W];
	assign mag_neg = ~mag + btpc_pkg::MAG_W'(1);

	always_comb begin
		if (neg_q) begin
			resp_fin = mag_neg[btpc_pkg::RESP_W-1:0];
		end else if (mag > btpc_pkg::MAG_W'({1'b0, {(btpc_pkg::RESP_W-1){1'b1}}})) begin
			resp_fin = {1'b0, {(btpc_pkg::RESP_W-1){1'b1}}};
		end else begin
			resp_fin = mag[btpc_pkg::RESP_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + btpc_pkg::CNT_W'(1);
					if (cnt_q == btpc_pkg::CNT_W'(btpc_pkg::Q_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			rem_q  <= btpc_pkg::REM_W'(ld_diff);
			sum_q  <= ld_sum;
			acc_q  <= '0;
			gmag_q <= gain[btpc_pkg::GAIN_W-1] ? ~gain + btpc_pkg::GAIN_W'(1) : gain;
			neg_q  <= gain[btpc_pkg::GAIN_W-1] ^ (req.plus > req.minus);
		end else if (state_q == ST_RUN) begin
			rem_q <= rem_next;
			acc_q <= acc_next;
		end
		if (state_q == ST_FIN) begin
			resp_q <= resp_fin;
		end
	end

	assign res.done = done_q;
	assign res.resp = resp_q;

	// a request only lands on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == ST_IDLE)
		else $error("axis unit started while busy");

	// fixed latency from request to result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && state_q == ST_IDLE) |-> ##(btpc_pkg::Q_W + 2) done_q)
		else $error("axis unit result late");

	// quotient never exceeds 1.0
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> rem_q < {sum_q, 1'b0} || sum_q == '0)
		else $error("divide remainder out of range");

endmodule

@@ hw/rtl/btpc_pos.sv @@
// Mirror position registers and their update for all four commands.
module btpc_pos (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     upd,
	input  btpc_pkg::cmd_t                           cmd,
	input  logic                                     axis,
	input  logic signed [btpc_pkg::MANUAL_W-1:0]     manual,
	input  logic signed [btpc_pkg::RESP_W-1:0]       hr,
	input  logic signed [btpc_pkg::RESP_W-1:0]       vr,
	output logic [btpc_pkg::POSITION_BITS-1:0]       hpos_next,
	output logic [btpc_pkg::POSITION_BITS-1:0]       vpos_next
);

	localparam int STEP_W = btpc_pkg::RESP_W + 1 - btpc_pkg::FRAC_BITS;
	localparam int ADD_A  = (btpc_pkg::POSITION_BITS + 1 > STEP_W) ?
		btpc_pkg::POSITION_BITS + 1 : STEP_W;
	localparam int ADD_B  = (ADD_A > btpc_pkg::MANUAL_W) ? ADD_A : btpc_pkg::MANUAL_W;
	localparam int ADD_W  = ADD_B + 1;
	localparam int T_W    = btpc_pkg::RESP_W + 1;

	// (resp + half) / one, truncated toward zero
	function automatic logic signed [STEP_W-1:0] step_of(input logic signed [btpc_pkg::RESP_W-1:0] r);
		logic signed [T_W-1:0]    t;
		logic signed [STEP_W-1:0] q;
		t = T_W'(r) + (T_W'(1) << (btpc_pkg::FRAC_BITS - 1));
		q = t[T_W-1:btpc_pkg::FRAC_BITS];
		if (t[T_W-1] && t[btpc_pkg::FRAC_BITS-1:0] != '0) begin
			q = q + STEP_W'(1);
		end
		return q;
	endfunction

	// saturate to the position range
	function automatic logic [btpc_pkg::POSITION_BITS-1:0] clamp(input logic signed [ADD_W-1:0] v);
		logic [btpc_pkg::POSITION_BITS-1:0] c;
		if (v[ADD_W-1]) begin
			c = '0;
		end else if (v > ADD_W'({btpc_pkg::POSITION_BITS{1'b1}})) begin
			c = '1;
		end else begin
			c = v[btpc_pkg::POSITION_BITS-1:0];
		end
		return c;
	endfunction

	logic [btpc_pkg::POSITION_BITS-1:0] hpos_q;
	logic [btpc_pkg::POSITION_BITS-1:0] vpos_q;
	logic signed [ADD_W-1:0]            h_ext;
	logic signed [ADD_W-1:0]            v_ext;
	logic signed [ADD_W-1:0]            man_ext;
	logic signed [ADD_W-1:0]            sel_ext;
	logic [btpc_pkg::POSITION_BITS-1:0] manual_pos;

	assign h_ext   = ADD_W'({1'b0, hpos_q});
	assign v_ext   = ADD_W'({1'b0, vpos_q});
	assign man_ext = ADD_W'(manual);
	assign sel_ext = axis ? v_ext : h_ext;

	// next positions
	always_comb begin
		hpos_next  = hpos_q;
		vpos_next  = vpos_q;
		manual_pos = clamp(man_ext);
		case (cmd)
			btpc_pkg::CMD_TRACK: begin
				hpos_next = clamp(h_ext + ADD_W'(step_of(hr)));
				vpos_next = clamp(v_ext + ADD_W'(step_of(vr)));
			end
			btpc_pkg::CMD_CHECK: begin
			end
			btpc_pkg::CMD_SET, btpc_pkg::CMD_ADD: begin
				if (cmd == btpc_pkg::CMD_ADD) begin
					manual_pos = clamp(sel_ext + man_ext);
				end
				if (axis) begin
					vpos_next = manual_pos;
				end else begin
					hpos_next = manual_pos;
				end
			end
			default: begin
			end
		endcase
	end

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= '0;
			vpos_q <= '0;
		end else if (upd) begin
			hpos_q <= hpos_next;
			vpos_q <= vpos_next;
		end
	end

	// check mode leaves both mirrors alone
	a_check_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && cmd == btpc_pkg::CMD_CHECK) |=> $stable(hpos_q) && $stable(vpos_q))
		else $error("check command moved a mirror");

	// set/add on the vertical mirror leaves the horizontal mirror alone
	a_other_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (cmd == btpc_pkg::CMD_SET || cmd == btpc_pkg::CMD_ADD) && axis)
		|=> $stable(hpos_q))
		else $error("manual command moved the other mirror");

endmodule

@@ hw/rtl/beam_tracking_p_controller.sv @@
// Track/check: after accept the shared axis unit resolves the horizontal, then the
// vertical response, one quotient bit per cycle for each axis in turn, and the result
// is registered in ST_UPDATE; set/add go straight from accept to ST_UPDATE. A new
// request is accepted only once the previous one has left ST_UPDATE.
// A result waiting on m_tready holds back the next update, not the next accept.
// Reset (arst_n low, asynchronous): mirrors at 0, gain 1.0, no result pending.
module beam_tracking_p_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// manual_value, horiz_plus_level, horiz_minus_level, vert_plus_level,
	// vert_minus_level, zero pad
	input  logic [btpc_pkg::S_TDATA_W-1:0]     s_tdata,
	// command, axis
	input  logic [btpc_pkg::USER_W-1:0]        s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// horiz_response, vert_response, horiz_position_out, vert_position_out
	output logic [btpc_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [btpc_pkg::GAIN_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HSTART,
		ST_HWAIT,
		ST_VSTART,
		ST_VWAIT,
		ST_UPDATE
	} state_t;

	state_t                                 state_q;
	logic                                   m_tvalid_q;
	logic [btpc_pkg::M_TDATA_W-1:0]         m_tdata_q;
	logic signed [btpc_pkg::GAIN_W-1:0]     gain_q;

	btpc_pkg::cmd_t                         cmd_q;
	logic                                   axis_q;
	logic signed [btpc_pkg::MANUAL_W-1:0]   manual_q;
	logic [btpc_pkg::LEVEL_BITS-1:0]        hp_q;
	logic [btpc_pkg::LEVEL_BITS-1:0]        hm_q;
	logic [btpc_pkg::LEVEL_BITS-1:0]        vp_q;
	logic [btpc_pkg::LEVEL_BITS-1:0]        vm_q;
	logic signed [btpc_pkg::RESP_W-1:0]     hr_q;
	logic signed [btpc_pkg::RESP_W-1:0]     vr_q;

	btpc_pkg::div_req_t                     req;
	btpc_pkg::div_res_t                     res;
	logic                                   in_fire;
	logic                                   out_free;
	logic                                   upd;
	logic                                   manual_cmd;
	logic [btpc_pkg::POSITION_BITS-1:0]     hpos_next;
	logic [btpc_pkg::POSITION_BITS-1:0]     vpos_next;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign upd        = (state_q == ST_UPDATE) && out_free;
	assign manual_cmd = s_tuser[btpc_pkg::CMD_W-1];
	assign cfg_ready  = 1'b1;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	// axis unit request: horizontal first, then vertical
	always_comb begin
		req.start = (state_q == ST_HSTART) || (state_q == ST_VSTART);
		req.plus  = (state_q == ST_HSTART) ? hp_q : vp_q;
		req.minus = (state_q == ST_HSTART) ? hm_q : vm_q;
	end

	btpc_axis_unit u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.gain   (gain_q),
		.res    (res)
	);

	btpc_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.cmd       (cmd_q),
		.axis      (axis_q),
		.manual    (manual_q),
		.hr        (hr_q),
		.vr        (vr_q),
		.hpos_next (hpos_next),
		.vpos_next (vpos_next)
	);

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			gain_q     <= btpc_pkg::GAIN_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gain_q <= cfg_data;
			end
			// result register: loaded on update, cleared once taken
			if (upd) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= manual_cmd ? ST_UPDATE : ST_HSTART;
					end
				end
				ST_HSTART: state_q <= ST_HWAIT;
				ST_HWAIT: begin
					if (res.done) begin
						state_q <= ST_VSTART;
					end
				end
				ST_VSTART: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (res.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, responses, result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q    <= btpc_pkg::cmd_t'(s_tuser[btpc_pkg::CMD_W-1:0]);
			axis_q   <= s_tuser[btpc_pkg::CMD_W];
			manual_q <= s_tdata[btpc_pkg::OFS_MAN +: btpc_pkg::MANUAL_W];
			hp_q     <= s_tdata[btpc_pkg::OFS_HP +: btpc_pkg::LEVEL_BITS];
			hm_q     <= s_tdata[btpc_pkg::OFS_HM +: btpc_pkg::LEVEL_BITS];
			vp_q     <= s_tdata[btpc_pkg::OFS_VP +: btpc_pkg::LEVEL_BITS];
			vm_q     <= s_tdata[btpc_pkg::OFS_VM +: btpc_pkg::LEVEL_BITS];
			// manual commands report zero responses
			hr_q     <= '0;
			vr_q     <= '0;
		end
		if (state_q == ST_HWAIT && res.done) begin
			hr_q <= res.resp;
		end
		if (state_q == ST_VWAIT && res.done) begin
			vr_q <= res.resp;
		end
		if (upd) begin
			m_tdata_q <= btpc_pkg::M_TDATA_W'({vpos_next, hpos_next, vr_q, hr_q});
		end
	end

	// manual commands leave both response fields zero
	a_manual_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (cmd_q == btpc_pkg::CMD_SET || cmd_q == btpc_pkg::CMD_ADD))
		|=> m_tdata[2*btpc_pkg::RESP_W-1:0] == '0)
		else $error("nonzero response on manual command");

endmodule

@@ verif/beam_tracking_p_controller_tb.sv @@
module beam_tracking_p_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import btpc_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     SETTLE      = 50;
	localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
	localparam longint HALF_Q      = longint'(1) << (FRAC_BITS - 1);
	localparam longint MIRROR_MAX  = (longint'(1) << POSITION_BITS) - 1;
	localparam longint RESP_MAX    = 64'sd2147483647;
	localparam longint RESP_MIN    = -64'sd2147483648;

	typedef struct {
		longint hr;
		longint vr;
		longint hpos;
		longint vpos;
	} beam_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [USER_W-1:0]      s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [GAIN_W-1:0]      cfg_data = '0;

	// predictor state
	logic signed [GAIN_W-1:0] gain_q = GAIN_RESET;
	longint                   horiz_mirror = 0;
	longint                   vert_mirror = 0;

	beam_result_t pending_results[$];
	int           gap_pct = 8;
	int           errors = 0;
	int           cycle_count = 0;

	beam_tracking_p_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= gap_pct);
	end

	// normalized error times gain for one axis, saturated to 32 bits
	function automatic longint axis_drive(input logic [LEVEL_BITS-1:0] plus,
					      input logic [LEVEL_BITS-1:0] minus);
		longint p, n, sum, err, resp;
		p = longint'(plus);
		n = longint'(minus);
		sum = p + n;
		err = 0;
		if (sum != 0)
			err = ((n - p) * ONE_Q) / sum;
		resp = (longint'(gain_q) * err) / ONE_Q;
		if (resp > RESP_MAX)
			resp = RESP_MAX;
		if (resp < RESP_MIN)
			resp = RESP_MIN;
		return resp;
	endfunction

	function automatic longint clamp_mirror(input longint v);
		if (v < 0)
			return 0;
		if (v > MIRROR_MAX)
			return MIRROR_MAX;
		return v;
	endfunction

	// rounded mirror move for a response
	function automatic longint mirror_step(input longint resp);
		return (resp + HALF_Q) / ONE_Q;
	endfunction

	// expected result for one request; updates the mirror positions
	function automatic beam_result_t predict_beam_result(input cmd_t cmd, input logic ax,
			input logic signed [MANUAL_W-1:0] man,
			input logic [LEVEL_BITS-1:0] hp, input logic [LEVEL_BITS-1:0] hm,
			input logic [LEVEL_BITS-1:0] vp, input logic [LEVEL_BITS-1:0] vm);
		beam_result_t r;
		r.hr = 0;
		r.vr = 0;
		if (cmd == CMD_TRACK || cmd == CMD_CHECK) begin
			r.hr = axis_drive(hp, hm);
			r.vr = axis_drive(vp, vm);
			if (cmd == CMD_TRACK) begin
				horiz_mirror = clamp_mirror(horiz_mirror + mirror_step(r.hr));
				vert_mirror = clamp_mirror(vert_mirror + mirror_step(r.vr));
			end
		end else if (cmd == CMD_SET) begin
			if (ax)
				vert_mirror = clamp_mirror(longint'(man));
			else
				horiz_mirror = clamp_mirror(longint'(man));
		end else begin
			if (ax)
				vert_mirror = clamp_mirror(vert_mirror + longint'(man));
			else
				horiz_mirror = clamp_mirror(horiz_mirror + longint'(man));
		end
		r.hpos = horiz_mirror;
		r.vpos = vert_mirror;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		beam_result_t want;
		logic signed [RESP_W-1:0] got_hr, got_vr;
		logic [POSITION_BITS-1:0] got_hpos, got_vpos;
		if (arst_n && m_tvalid && m_tready) begin
			got_hr = m_tdata[0 +: RESP_W];
			got_vr = m_tdata[RESP_W +: RESP_W];
			got_hpos = m_tdata[2 * RESP_W +: POSITION_BITS];
			got_vpos = m_tdata[2 * RESP_W + POSITION_BITS +: POSITION_BITS];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, horiz_response", longint'(got_hr), 0);
			end else begin
				want = pending_results.pop_front();
				if (longint'(got_hr) != want.hr)
					report_mismatch("horiz_response", longint'(got_hr), want.hr);
				if (longint'(got_vr) != want.vr)
					report_mismatch("vert_response", longint'(got_vr), want.vr);
				if (longint'(got_hpos) != want.hpos)
					report_mismatch("horiz_position_out", longint'(got_hpos), want.hpos);
				if (longint'(got_vpos) != want.vpos)
					report_mismatch("vert_position_out", longint'(got_vpos), want.vpos);
			end
		end
	end

	// one request on the input stream, with random idle cycles ahead of it
	task automatic send_request(input cmd_t cmd, input logic ax,
			input logic signed [MANUAL_W-1:0] man,
			input logic [LEVEL_BITS-1:0] hp, input logic [LEVEL_BITS-1:0] hm,
			input logic [LEVEL_BITS-1:0] vp, input logic [LEVEL_BITS-1:0] vm);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[OFS_MAN +: MANUAL_W] = man;
		word[OFS_HP +: LEVEL_BITS] = hp;
		word[OFS_HM +: LEVEL_BITS] = hm;
		word[OFS_VP +: LEVEL_BITS] = vp;
		word[OFS_VM +: LEVEL_BITS] = vm;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= {ax, cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(predict_beam_result(cmd, ax, man, hp, hm, vp, vm));
	endtask

	// drop valid and let every outstanding result come back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] value);
		wait_for_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		gain_q = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sensor level biased toward the edges
	function automatic logic [LEVEL_BITS-1:0] pick_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return LEVEL_BITS'($urandom_range(15));
			3: return '1 - LEVEL_BITS'($urandom_range(15));
			default: return LEVEL_BITS'($urandom);
		endcase
	endfunction

	function automatic logic signed [MANUAL_W-1:0] pick_manual();
		case ($urandom_range(9))
			0: return 17'sd65535;
			1: return -17'sd65535;
			2: return 17'h10000;
			3: return '0;
			4, 5, 6: return MANUAL_W'(int'($urandom_range(600)) - 300);
			default: return MANUAL_W'($urandom);
		endcase
	endfunction

	function automatic cmd_t pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return CMD_TRACK;
		if (r < 70)
			return CMD_CHECK;
		if (r < 85)
			return CMD_SET;
		return CMD_ADD;
	endfunction

	task automatic run_random_requests(input int count);
		for (int i = 0; i < count; i++)
			send_request(pick_command(), 1'($urandom), pick_manual(),
				     pick_level(), pick_level(), pick_level(), pick_level());
	endtask

	// zero sum, full-scale error both ways, equal levels, rounding of small errors
	task automatic test_sensor_extremes();
		send_request(CMD_TRACK, 1'b0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(CMD_TRACK, 1'b0, '0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		send_request(CMD_CHECK, 1'b1, '0, 16'h0001, 16'hffff, 16'hffff, 16'hffff);
		send_request(CMD_TRACK, 1'b0, '0, 16'h1234, 16'h1234, 16'h0000, 16'h0001);
		send_request(CMD_CHECK, 1'b0, '0, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
		send_request(CMD_TRACK, 1'b1, '0, 16'h0003, 16'h0005, 16'h0007, 16'h0002);
	endtask

	// set and add on both mirrors, saturating at both ends
	task automatic test_manual_moves();
		send_request(CMD_SET, 1'b0, 17'sd65535, pick_level(), pick_level(),
			     pick_level(), pick_level());
		send_request(CMD_SET, 1'b1, -17'sd65535, '1, '0, '1, '0);
		send_request(CMD_ADD, 1'b1, -17'sd5, '0, '1, '0, '1);
		send_request(CMD_ADD, 1'b0, 17'sd1, pick_level(), pick_level(),
			     pick_level(), pick_level());
		send_request(CMD_SET, 1'b1, 17'h10000, '0, '0, '0, '0);
		send_request(CMD_ADD, 1'b0, -17'sd65535, '1, '1, '1, '1);
		send_request(CMD_SET, 1'b0, 17'sd300, pick_level(), pick_level(),
			     pick_level(), pick_level());
		send_request(CMD_ADD, 1'b1, 17'sd65535, pick_level(), pick_level(),
			     pick_level(), pick_level());
	endtask

	// gain extremes: response saturation and mirrors driven to their limits
	task automatic test_gain_extremes();
		write_gain(32'h8000_0000);
		send_request(CMD_TRACK, 1'b0, '0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		send_request(CMD_TRACK, 1'b0, '0, 16'h0000, 16'hffff, 16'hffff, 16'h0000);
		write_gain(32'h7fff_ffff);
		send_request(CMD_CHECK, 1'b0, '0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		send_request(CMD_TRACK, 1'b1, '0, 16'h0000, 16'hffff, 16'h0001, 16'h0000);
		write_gain(32'h0000_0000);
		send_request(CMD_TRACK, 1'b0, '0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		write_gain(32'hffff_ffff);
		send_request(CMD_TRACK, 1'b0, '0, 16'h0000, 16'hffff, 16'h8000, 16'h0001);
	endtask

	// random requests over a sweep of gains
	task automatic test_random_sweep();
		logic [GAIN_W-1:0] gains[8];
		gains = '{GAIN_RESET, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
			  32'h0032_0000, 32'hffce_0000, 32'hffff_ffff, 32'h0};
		gains[7] = $urandom;
		for (int ph = 0; ph < 8; ph++) begin
			write_gain(gains[ph]);
			// one phase runs with no idling on either side
			gap_pct = (ph == 4) ? 0 : 8;
			run_random_requests(40);
			// hold the sender off until everything is back
			if (ph == 2)
				wait_for_results();
			run_random_requests(40);
		end
		gap_pct = 8;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_sensor_extremes();
		test_manual_moves();
		test_gain_extremes();
		test_random_sweep();

		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ beam_tracking_p_controller.f @@
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_axis_unit.sv
hw/rtl/btpc_pos.sv
hw/rtl/beam_tracking_p_controller.sv
verif/beam_tracking_p_controller_tb.sv
